### hw/rtl/poc_pkg.sv
// Shared types and constants of the placement order checker.
package poc_pkg;

    localparam int ATOM_W    = 10;
    localparam int NUM_W     = 11;
    localparam int IDX_W     = 10;
    localparam int STAT_W    = 3;
    localparam int EPOCH_W   = 8;
    localparam int MAP_DEPTH = 1 << ATOM_W;

    localparam logic [NUM_W-1:0]   MAX_ATOMS = NUM_W'(1024);
    localparam logic [NUM_W-1:0]   ROOT_NUM  = NUM_W'(3);
    localparam logic [IDX_W-1:0]   INDEX_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [ATOM_W-1:0]  ADDR_LAST = '1;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_ROOT_REPEAT = 3'd1;
    localparam logic [STAT_W-1:0] ST_ROOT_RANGE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ATOM_RANGE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PLACED      = 3'd4;
    localparam logic [STAT_W-1:0] ST_UNPLACED    = 3'd5;
    localparam logic [STAT_W-1:0] ST_COUNT       = 3'd6;

    localparam logic [1:0] CFG_ATOM_COUNT  = 2'd0;
    localparam logic [1:0] CFG_ROOT_FIRST  = 2'd1;
    localparam logic [1:0] CFG_ROOT_SECOND = 2'd2;
    localparam logic [1:0] CFG_ROOT_THIRD  = 2'd3;

    typedef struct packed {
        logic [NUM_W-1:0]  atom_count;
        logic [ATOM_W-1:0] root_first;
        logic [ATOM_W-1:0] root_second;
        logic [ATOM_W-1:0] root_third;
    } poc_cfg_t;

    typedef struct packed {
        logic              action;
        logic [ATOM_W-1:0] new_atom;
        logic [ATOM_W-1:0] ref_near;
        logic [ATOM_W-1:0] ref_mid;
        logic [ATOM_W-1:0] ref_far;
    } poc_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  entry_index;
        logic              done_res;
    } poc_res_t;

endpackage

### hw/rtl/poc_map_ram.sv
// Placed map memory: epoch tag per atom, two registered read ports, one write port.
module poc_map_ram
    import poc_pkg::*;
(
    input  logic               clk,
    input  logic               rd_en,
    input  logic [ATOM_W-1:0]  rd_addr_a,
    input  logic [ATOM_W-1:0]  rd_addr_b,
    output logic [EPOCH_W-1:0] rd_data_a,
    output logic [EPOCH_W-1:0] rd_data_b,
    input  logic               wr_en,
    input  logic [ATOM_W-1:0]  wr_addr,
    input  logic [EPOCH_W-1:0] wr_data
);

    logic [EPOCH_W-1:0] mem [MAP_DEPTH];
    logic [EPOCH_W-1:0] rd_a_reg;
    logic [EPOCH_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### hw/rtl/poc_core.sv
// Check engine: two-phase map lookup, verdict stage, check state and map clearing.
module poc_core
    import poc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  poc_cfg_t  cfg,
    input  logic      in_vld,
    input  poc_item_t in_item,
    output logic      in_rdy,
    input  logic      out_free,
    output logic      res_vld,
    output poc_res_t  res
);

    poc_item_t          iss_item_reg;
    logic               iss_vld_reg;
    logic               iss_ph_reg;
    poc_item_t          e_item_reg;
    logic               e_vld_reg;
    logic [EPOCH_W-1:0] e_rd0_reg;
    logic [EPOCH_W-1:0] e_rd1_reg;
    logic               e_hit0_reg;
    logic               e_hit1_reg;

    logic               active_reg;
    logic [STAT_W-1:0]  err_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [ATOM_W-1:0]  r1_reg;
    logic [ATOM_W-1:0]  r2_reg;
    logic [ATOM_W-1:0]  r3_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               lastw_vld_reg;
    logic [ATOM_W-1:0]  lastw_addr_reg;
    logic               clr_reg;
    logic [ATOM_W-1:0]  clr_addr_reg;

    logic               e_fire;
    logic               e_free;
    logic               issue0;
    logic               issue1;
    logic               clr_start;
    logic [EPOCH_W-1:0] rd_a;
    logic [EPOCH_W-1:0] rd_b;

    logic               start;
    logic [NUM_W-1:0]   n_eff;
    logic [ATOM_W-1:0]  r1;
    logic [ATOM_W-1:0]  r2;
    logic [ATOM_W-1:0]  r3;
    logic [STAT_W-1:0]  root_err;
    logic [STAT_W-1:0]  err_base;
    logic [IDX_W-1:0]   cnt_base;
    logic [EPOCH_W-1:0] epoch_eff;
    logic               p0;
    logic               p1;
    logic               p2;
    logic               p3;
    logic               any_range;
    logic [STAT_W-1:0]  err_next;
    logic [IDX_W-1:0]   cnt_next;
    logic               mark;
    logic               mismatch;

    logic               wr_en;
    logic [ATOM_W-1:0]  wr_addr;
    logic [EPOCH_W-1:0] wr_data;

    assign e_fire    = e_vld_reg && out_free;
    assign e_free    = !e_vld_reg || e_fire;
    assign clr_start = e_fire && e_item_reg.action && (epoch_eff == EPOCH_MAX);
    assign issue0    = iss_vld_reg && !iss_ph_reg && e_free && !clr_reg && !clr_start;
    assign issue1    = iss_vld_reg && iss_ph_reg;
    assign in_rdy    = !iss_vld_reg || issue1;

    always_comb
    begin
        n_eff     = (cfg.atom_count > MAX_ATOMS) ? MAX_ATOMS : cfg.atom_count;
        start     = !active_reg;
        r1        = start ? cfg.root_first  : r1_reg;
        r2        = start ? cfg.root_second : r2_reg;
        r3        = start ? cfg.root_third  : r3_reg;
        epoch_eff = start ? epoch_reg + EPOCH_W'(1) : epoch_reg;
        cnt_base  = start ? '0 : cnt_reg;

        if (r1 == r2 || r1 == r3 || r2 == r3)
        begin
            root_err = ST_ROOT_REPEAT;
        end
        else if ({1'b0, r1} >= n_eff || {1'b0, r2} >= n_eff || {1'b0, r3} >= n_eff)
        begin
            root_err = ST_ROOT_RANGE;
        end
        else
        begin
            root_err = ST_OK;
        end
        err_base = start ? root_err : err_reg;

        p0 = e_hit0_reg || (e_rd0_reg == epoch_eff) || e_item_reg.new_atom == r1
             || e_item_reg.new_atom == r2 || e_item_reg.new_atom == r3;
        p1 = e_hit1_reg || (e_rd1_reg == epoch_eff) || e_item_reg.ref_near == r1
             || e_item_reg.ref_near == r2 || e_item_reg.ref_near == r3;
        p2 = (rd_a == epoch_eff) || e_item_reg.ref_mid == r1
             || e_item_reg.ref_mid == r2 || e_item_reg.ref_mid == r3;
        p3 = (rd_b == epoch_eff) || e_item_reg.ref_far == r1
             || e_item_reg.ref_far == r2 || e_item_reg.ref_far == r3;

        any_range = {1'b0, e_item_reg.new_atom} >= n_eff
                    || {1'b0, e_item_reg.ref_near} >= n_eff
                    || {1'b0, e_item_reg.ref_mid} >= n_eff
                    || {1'b0, e_item_reg.ref_far} >= n_eff;

        mark     = 1'b0;
        err_next = err_base;
        if (err_base == ST_OK)
        begin
            if (any_range)
            begin
                err_next = ST_ATOM_RANGE;
            end
            else if (p0)
            begin
                err_next = ST_PLACED;
            end
            else if (!p1 || !p2 || !p3)
            begin
                err_next = ST_UNPLACED;
            end
            else
            begin
                mark = 1'b1;
            end
        end
        cnt_next = (cnt_base < INDEX_MAX) ? cnt_base + IDX_W'(1) : cnt_base;
        mismatch = (n_eff < ROOT_NUM) || ((n_eff - ROOT_NUM) != {1'b0, cnt_base});

        if (e_item_reg.action)
        begin
            res.status      = mismatch ? ST_COUNT : err_base;
            res.entry_index = cnt_base;
            res.done_res    = 1'b1;
        end
        else
        begin
            res.status      = err_next;
            res.entry_index = cnt_next;
            res.done_res    = 1'b0;
        end
    end

    assign res_vld = e_fire;

    always_comb
    begin
        if (clr_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = e_fire && !e_item_reg.action && mark;
            wr_addr = e_item_reg.new_atom;
            wr_data = epoch_eff;
        end
    end

    poc_map_ram u_map
    (
        .clk       (clk),
        .rd_en     (issue0 || issue1),
        .rd_addr_a (issue0 ? iss_item_reg.new_atom : iss_item_reg.ref_mid),
        .rd_addr_b (issue0 ? iss_item_reg.ref_near : iss_item_reg.ref_far),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            iss_item_reg <= in_item;
        end
        if (issue1)
        begin
            e_item_reg <= iss_item_reg;
            e_rd0_reg  <= rd_a;
            e_rd1_reg  <= rd_b;
            e_hit0_reg <= lastw_vld_reg && (lastw_addr_reg == iss_item_reg.new_atom);
            e_hit1_reg <= lastw_vld_reg && (lastw_addr_reg == iss_item_reg.ref_near);
        end
        if (e_fire)
        begin
            lastw_addr_reg <= e_item_reg.new_atom;
            cnt_reg        <= cnt_next;
            if (start)
            begin
                r1_reg <= cfg.root_first;
                r2_reg <= cfg.root_second;
                r3_reg <= cfg.root_third;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_vld_reg   <= 1'b0;
            iss_ph_reg    <= 1'b0;
            e_vld_reg     <= 1'b0;
            active_reg    <= 1'b0;
            err_reg       <= ST_OK;
            epoch_reg     <= '0;
            lastw_vld_reg <= 1'b0;
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (in_vld && in_rdy)
            begin
                iss_vld_reg <= 1'b1;
            end
            else if (issue1)
            begin
                iss_vld_reg <= 1'b0;
            end

            if (issue0)
            begin
                iss_ph_reg <= 1'b1;
            end
            else if (issue1)
            begin
                iss_ph_reg <= 1'b0;
            end

            if (issue1)
            begin
                e_vld_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_vld_reg <= 1'b0;
            end

            if (e_fire)
            begin
                active_reg    <= !e_item_reg.action;
                err_reg       <= e_item_reg.action ? err_base : err_next;
                epoch_reg     <= clr_start ? '0 : epoch_eff;
                lastw_vld_reg <= !e_item_reg.action && mark;
            end

            // sweep the map back to epoch zero before tags wrap
            if (clr_start)
            begin
                clr_reg      <= 1'b1;
                clr_addr_reg <= '0;
            end
            else if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ATOM_W'(1);
                if (clr_addr_reg == ADDR_LAST)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

endmodule

### hw/rtl/placement_order_checker.sv
// Top level of the placement order checker: ports, configuration registers, result register.
//
//  channel | signals                          | moves
//  --------+----------------------------------+---------------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tlast| entry or end marker, one per transfer
//  m_      | m_tvalid m_tready m_tdata m_tlast| one result per input transfer
//  cfg_    | cfg_valid cfg_ready cfg_index/data| register write, always accepted
//
//  Each item is looked up in two phases (new_atom and ref_near, then ref_mid and ref_far) on
//  the map memory's two read ports; a new transfer is taken as the second phase issues.
//  After reset the whole map of 1024 atoms is cleared before the first lookup; the same pass
//  follows every 255th end marker. One input transfer is still taken then.
//  A stalled result holds the verdict stage, which in turn holds the lookups.
module placement_order_checker
    import poc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // new_atom, ref_near, ref_mid, ref_far
    input  logic             s_tlast,   // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // status, entry_index, zero fill
    output logic             m_tlast,   // done_res
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [NUM_W-1:0] cfg_data
);

    poc_cfg_t  cfg_reg;
    poc_item_t in_item;
    poc_res_t  res;
    poc_res_t  out_reg;
    logic      out_vld_reg;
    logic      res_vld;
    logic      out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.atom_count  <= NUM_W'(3);
            cfg_reg.root_first  <= ATOM_W'(0);
            cfg_reg.root_second <= ATOM_W'(1);
            cfg_reg.root_third  <= ATOM_W'(2);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ATOM_COUNT:  cfg_reg.atom_count  <= cfg_data;
                CFG_ROOT_FIRST:  cfg_reg.root_first  <= cfg_data[ATOM_W-1:0];
                CFG_ROOT_SECOND: cfg_reg.root_second <= cfg_data[ATOM_W-1:0];
                CFG_ROOT_THIRD:  cfg_reg.root_third  <= cfg_data[ATOM_W-1:0];
                default:         cfg_reg.atom_count  <= cfg_reg.atom_count;
            endcase
        end
    end

    assign in_item.action   = s_tlast;
    assign in_item.new_atom = s_tdata[9:0];
    assign in_item.ref_near = s_tdata[19:10];
    assign in_item.ref_mid  = s_tdata[29:20];
    assign in_item.ref_far  = s_tdata[39:30];

    assign out_free = !out_vld_reg || m_tready;

    poc_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_vld   (s_tvalid),
        .in_item  (in_item),
        .in_rdy   (s_tready),
        .out_free (out_free),
        .res_vld  (res_vld),
        .res      (res)
    );

    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= res_vld;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.entry_index, out_reg.status};
    assign m_tlast  = out_reg.done_res;

endmodule
